// ===== rtl/tds_pkg.sv =====
// Package for the turnstile door sequencer: phase codes, register indexes,
// configuration, item and result types, reset values. No dependencies.
`default_nettype none

package tds_pkg;

    localparam int unsigned MsW   = 16;
    localparam int unsigned DistW = 13;
    localparam int unsigned IdxW  = 3;

    localparam logic [MsW-1:0] MsMax = '1;

    typedef enum logic [3:0] {
        PH_INIT       = 4'd0,
        PH_SCAN       = 4'd1,
        PH_REJECT     = 4'd2,
        PH_OPEN       = 4'd3,
        PH_WAIT_OPEN  = 4'd4,
        PH_WAIT_ENTRY = 4'd5,
        PH_AFTER      = 4'd6,
        PH_CLOSE      = 4'd7,
        PH_WAIT_CLOSE = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_GRANTED = 2'd1,
        VERDICT_REJECT  = 2'd2,
        VERDICT_SPARE   = 2'd3
    } t_verdict;

    typedef enum logic [IdxW-1:0] {
        CFG_SENSOR_PRESENT = 3'd0,
        CFG_OPEN_DELAY     = 3'd1,
        CFG_SENSOR_SETTLE  = 3'd2,
        CFG_ENTRY_TIMEOUT  = 3'd3,
        CFG_AFTER_ENTRY    = 3'd4,
        CFG_CLOSE_WAIT     = 3'd5,
        CFG_DISTANCE_LOW   = 3'd6,
        CFG_DISTANCE_HIGH  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic             sensor_present;
        logic [MsW-1:0]   open_delay_ms;
        logic [MsW-1:0]   sensor_settle_ms;
        logic [MsW-1:0]   entry_timeout_ms;
        logic [MsW-1:0]   after_entry_ms;
        logic [MsW-1:0]   close_wait_ms;
        logic [DistW-1:0] distance_low_mm;
        logic [DistW-1:0] distance_high_mm;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        sensor_present:   1'b1,
        open_delay_ms:    16'd3000,
        sensor_settle_ms: 16'd500,
        entry_timeout_ms: 16'd10000,
        after_entry_ms:   16'd2000,
        close_wait_ms:    16'd1000,
        distance_low_mm:  13'd20,
        distance_high_mm: 13'd500
    };

    typedef struct packed {
        logic             ms_tick;
        logic             verdict_valid;
        logic [1:0]       verdict;
        logic             distance_valid;
        logic [DistW-1:0] distance_mm;
    } t_item;

    typedef struct packed {
        logic   door_drive;
        t_phase phase;
        logic   rejected_pulse;
        logic   passage_seen;
        logic   entry_timed_out;
    } t_result;

    typedef struct packed {
        t_phase         phase;
        logic [MsW-1:0] elapsed_ms;
        logic           door;
    } t_seq_state;

endpackage

`default_nettype wire

// ===== rtl/tds_cfg_regs.sv =====
// Configuration register bank of the door sequencer.
// Depends on tds_pkg.
`default_nettype none

module tds_cfg_regs
    import tds_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire logic [IdxW-1:0] i_index,
    input  wire logic [MsW-1:0]  i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_index))
                CFG_SENSOR_PRESENT: r_cfg.sensor_present   <= i_data[0];
                CFG_OPEN_DELAY:     r_cfg.open_delay_ms    <= i_data;
                CFG_SENSOR_SETTLE:  r_cfg.sensor_settle_ms <= i_data;
                CFG_ENTRY_TIMEOUT:  r_cfg.entry_timeout_ms <= i_data;
                CFG_AFTER_ENTRY:    r_cfg.after_entry_ms   <= i_data;
                CFG_CLOSE_WAIT:     r_cfg.close_wait_ms    <= i_data;
                CFG_DISTANCE_LOW:   r_cfg.distance_low_mm  <= i_data[DistW-1:0];
                CFG_DISTANCE_HIGH:  r_cfg.distance_high_mm <= i_data[DistW-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/tds_step.sv =====
// Next-state and result logic of the door sequencer for one request.
// Purely combinational; depends on tds_pkg.
`default_nettype none

module tds_step
    import tds_pkg::*;
(
    input  t_seq_state i_state,
    input  t_cfg       i_cfg,
    input  t_item      i_item,
    output t_seq_state o_state,
    output t_result    o_result
);

    logic [MsW-1:0] w_elapsed;
    logic           w_in_window;
    logic           w_tmo;
    logic           w_rej;

    assign w_elapsed = (i_item.ms_tick && (i_state.elapsed_ms != MsMax))
                     ? i_state.elapsed_ms + MsW'(1) : i_state.elapsed_ms;

    assign w_in_window = i_item.distance_valid
                      && (i_item.distance_mm > i_cfg.distance_low_mm)
                      && (i_item.distance_mm < i_cfg.distance_high_mm);

    always_comb begin
        o_state            = i_state;
        o_state.elapsed_ms = w_elapsed;
        w_tmo              = 1'b0;
        w_rej              = 1'b0;
        unique case (i_state.phase)
            PH_INIT: begin
                o_state.elapsed_ms = '0;
                o_state.phase      = PH_SCAN;
            end
            PH_SCAN: begin
                if (i_item.verdict_valid) begin
                    if (t_verdict'(i_item.verdict) == VERDICT_GRANTED) begin
                        o_state.phase = PH_OPEN;
                    end else if (t_verdict'(i_item.verdict) == VERDICT_REJECT) begin
                        o_state.phase = PH_REJECT;
                        w_rej         = 1'b1;
                    end
                end
            end
            PH_REJECT: begin
                o_state.phase = PH_INIT;
            end
            PH_OPEN: begin
                o_state.door       = 1'b1;
                o_state.elapsed_ms = '0;
                o_state.phase      = PH_WAIT_OPEN;
            end
            PH_WAIT_OPEN: begin
                if (i_cfg.sensor_present) begin
                    if (w_elapsed > i_cfg.sensor_settle_ms) begin
                        o_state.elapsed_ms = '0;
                        o_state.phase      = PH_WAIT_ENTRY;
                    end
                end else if (w_elapsed > i_cfg.open_delay_ms) begin
                    o_state.elapsed_ms = '0;
                    o_state.phase      = PH_AFTER;
                end
            end
            PH_WAIT_ENTRY: begin
                w_tmo = w_elapsed > i_cfg.entry_timeout_ms;
                if (w_tmo || w_in_window) begin
                    o_state.elapsed_ms = '0;
                    o_state.phase      = PH_AFTER;
                end
            end
            PH_AFTER: begin
                if (w_elapsed > i_cfg.after_entry_ms) begin
                    o_state.phase = PH_CLOSE;
                end
            end
            PH_CLOSE: begin
                o_state.door       = 1'b0;
                o_state.elapsed_ms = '0;
                o_state.phase      = PH_WAIT_CLOSE;
            end
            PH_WAIT_CLOSE: begin
                if (w_elapsed > i_cfg.close_wait_ms) begin
                    o_state.phase = PH_INIT;
                end
            end
            default: begin
                o_state.phase = PH_INIT;
            end
        endcase
    end

    always_comb begin
        o_result.door_drive      = o_state.door;
        o_result.phase           = o_state.phase;
        o_result.rejected_pulse  = w_rej;
        o_result.passage_seen    = w_in_window && (i_state.phase == PH_WAIT_ENTRY);
        o_result.entry_timed_out = w_tmo;
    end

endmodule

`default_nettype wire

// ===== rtl/turnstile_door_sequencer.sv =====
// Top level of the turnstile door sequencer: input register, phase state,
// result register. Depends on tds_pkg, tds_cfg_regs and tds_step.
//
//  channel   direction  tdata (low bit up)                        tuser
//  s_axis    in         ms_tick, verdict[1:0], distance_mm[12:0]   verdict_valid, distance_valid
//  m_axis    out        door_drive, phase[3:0], rejected_pulse,    -
//                       passage_seen, entry_timed_out
//  cfg       in         i_cfg_wr_en / i_cfg_index / i_cfg_data     -
//
// One request per cycle sustained while m_axis is not stalled; a request is
// loaded into the input register when it is taken, and its phase update goes
// into the result register once the output is free, which puts it on m_axis.
// Synchronous active-low reset clears phase, counter, door and valids.
// While the result waits, one more request is held in the input register.
`default_nettype none

module turnstile_door_sequencer
    import tds_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [15:0]     s_axis_tdata,  // ms_tick, verdict[1:0], distance_mm[12:0]
    input  wire logic [1:0]      s_axis_tuser,  // verdict_valid, distance_valid
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // door_drive, phase[3:0], rejected_pulse,
                                                // passage_seen, entry_timed_out
    input  wire logic            i_cfg_wr_en,
    input  wire logic [IdxW-1:0] i_cfg_index,
    input  wire logic [MsW-1:0]  i_cfg_data
);

    t_cfg       w_cfg;
    t_item      w_item;
    t_item      r_item;
    logic       r_in_valid;
    t_seq_state r_state;
    t_seq_state n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       w_out_free;
    logic       w_take;

    tds_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    tds_step u_step (
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_comb begin
        w_item.ms_tick        = s_axis_tdata[0];
        w_item.verdict        = s_axis_tdata[2:1];
        w_item.distance_mm    = s_axis_tdata[15:3];
        w_item.verdict_valid  = s_axis_tuser[0];
        w_item.distance_valid = s_axis_tuser[1];
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.phase <= PH_INIT;
            r_state.elapsed_ms <= '0;
            r_state.door  <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_out_free) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= w_item;
        end
        if (w_out_free && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.entry_timed_out, r_result.passage_seen,
                            r_result.rejected_pulse, r_result.phase,
                            r_result.door_drive};

endmodule

`default_nettype wire

// ===== rtl/tds_checker.sv =====
// Port-level checks for the turnstile door sequencer, bound to the top.
// Depends on tds_pkg and turnstile_door_sequencer.
`default_nettype none

module tds_checker
    import tds_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    logic   w_door;
    t_phase w_phase;

    assign w_door  = m_axis_tdata[0];
    assign w_phase = t_phase'(m_axis_tdata[4:1]);

    // door is released exactly from wait-open through close
    a_door_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_door == ((w_phase == PH_WAIT_OPEN)
                                   || (w_phase == PH_WAIT_ENTRY)
                                   || (w_phase == PH_AFTER)
                                   || (w_phase == PH_CLOSE))))
        else $error("door drive disagrees with phase");

    a_reject_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> (w_phase == PH_REJECT))
        else $error("reject pulse outside reject phase");

    a_entry_end_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[6] || m_axis_tdata[7]))
            |-> (w_phase == PH_AFTER) && w_door)
        else $error("entry end flag without after-entry phase");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind turnstile_door_sequencer tds_checker u_tds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
